>>> hdl/rbsi_pkg.sv
// Package for the ray/box slab interval block: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package rbsi_pkg;
	localparam int AXES = 3;
	localparam int WBITS = 32;

	// Classified item passed from the front part to the back part.
	typedef struct packed {
		logic [AXES-1:0][WBITS:0] num_lo;
		logic [AXES-1:0][WBITS:0] num_hi;
		logic [AXES-1:0][WBITS-1:0] dir;
		logic [AXES-1:0] active;
		logic in_slab;
		logic no_dir;
	} rbsi_job_t;
endpackage

>>> hdl/rbsi_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface rbsi_if #(parameter int W = 32) ();
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hdl/rbsi_front.sv
// Front part: accepts a request, classifies each axis, forms slab numerators.
// Depends on rbsi_pkg.
`timescale 1ns / 1ps
module rbsi_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [12*rbsi_pkg::WBITS-1:0] in_data,
	output logic job_valid,
	input logic job_ready,
	output rbsi_pkg::rbsi_job_t job
);
	localparam int WORD_BITS = rbsi_pkg::WBITS;

	// Two entry queue toward the back part.
	rbsi_pkg::rbsi_job_t q_mem_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	rbsi_pkg::rbsi_job_t nj;
	logic push, pop;

	always_comb begin
		logic signed [WORD_BITS-1:0] o, d, l, h;
		nj = '0;
		nj.in_slab = 1'b1;
		for (int a = 0; a < 3; a++) begin
			o = in_data[a*WORD_BITS +: WORD_BITS];
			d = in_data[(3+a)*WORD_BITS +: WORD_BITS];
			l = in_data[(6+2*a)*WORD_BITS +: WORD_BITS];
			h = in_data[(7+2*a)*WORD_BITS +: WORD_BITS];
			nj.dir[a] = d;
			nj.active[a] = (d != '0);
			nj.num_lo[a] = {l[WORD_BITS-1], l} - {o[WORD_BITS-1], o};
			nj.num_hi[a] = {h[WORD_BITS-1], h} - {o[WORD_BITS-1], o};
			if (d == '0 && (o < l || o > h)) nj.in_slab = 1'b0;
		end
		nj.no_dir = (nj.active == '0);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign job_valid = (cnt_q != 2'd0);
	assign pop = job_valid && job_ready;
	assign job = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wp_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ready) else $error("accept while full");
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("queue lost an entry");
endmodule

>>> hdl/rbsi_div.sv
// Pipelined saturating fixed point slab divider, one quotient bit per stage.
// Depends on nothing.
`timescale 1ns / 1ps
module rbsi_div #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic en,
	input logic [WORD_BITS:0] num,
	input logic [WORD_BITS-1:0] den,
	output logic signed [WORD_BITS-1:0] quo
);
	// Quotient of |num|*2^F/|den| needs up to WORD_BITS+1+F bits; anything
	// at or above 2^(W-1) saturates, so only the low QB bits are computed
	// and higher quotient bits are folded into an overflow flag.
	localparam int NB = WORD_BITS + 1 + FRAC_BITS;
	localparam int QB = WORD_BITS + 1;
	localparam int ST = NB;

	logic [NB-1:0] n_s [ST+1];
	logic [WORD_BITS:0] d_s [ST+1];
	logic [WORD_BITS+1:0] r_s [ST+1];
	logic [QB-1:0] q_s [ST+1];
	logic ov_s [ST+1];
	logic ng_s [ST+1];

	always_comb begin
		logic [WORD_BITS:0] an;
		logic [WORD_BITS:0] ad;
		an = num[WORD_BITS] ? (~num + 1'b1) : num;
		ad = den[WORD_BITS-1] ? ({1'b0, ~den} + 1'b1) : {1'b0, den};
		n_s[0] = {an, {FRAC_BITS{1'b0}}};
		d_s[0] = ad;
		r_s[0] = '0;
		q_s[0] = '0;
		ov_s[0] = 1'b0;
		ng_s[0] = num[WORD_BITS] ^ den[WORD_BITS-1];
	end

	for (genvar i = 0; i < ST; i++) begin : g_st
		logic [WORD_BITS+1:0] rs;
		logic ge;
		assign rs = {r_s[i][WORD_BITS:0], n_s[i][NB-1-i]};
		assign ge = rs >= {1'b0, d_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1] <= n_s[i];
				d_s[i+1] <= d_s[i];
				r_s[i+1] <= ge ? rs - {1'b0, d_s[i]} : rs;
				q_s[i+1] <= {q_s[i][QB-2:0], ge};
				ov_s[i+1] <= ov_s[i] | (ge && (NB-1-i) >= QB) | q_s[i][QB-1];
				ng_s[i+1] <= ng_s[i];
			end
		end
	end

	always_comb begin
		logic big;
		big = ov_s[ST] || q_s[ST][QB-1];
		if (ng_s[ST]) begin
			if (big || q_s[ST][QB-2:0] > {1'b1, {(QB-2){1'b0}}})
				quo = {1'b1, {(WORD_BITS-1){1'b0}}};
			else quo = WORD_BITS'(~q_s[ST][QB-2:0] + 1'b1);
		end else begin
			if (big || q_s[ST][QB-2]) quo = {1'b0, {(WORD_BITS-1){1'b1}}};
			else quo = WORD_BITS'(q_s[ST][QB-2:0]);
		end
	end
endmodule

>>> hdl/rbsi_back.sv
// Back part: six slab dividers in one pipeline that stalls as a whole, then interval merge.
// Depends on rbsi_pkg and rbsi_div.
`timescale 1ns / 1ps
module rbsi_back #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input rbsi_pkg::rbsi_job_t job,
	output logic out_valid,
	input logic out_ready,
	output logic [2*rbsi_pkg::WBITS+1:0] out_data
);
	localparam int WORD_BITS = rbsi_pkg::WBITS;
	localparam int LAT = WORD_BITS + 1 + FRAC_BITS;

	logic en;
	logic v_s [LAT+1];
	logic [2:0] act_s [LAT+1];
	logic ins_s [LAT+1];
	logic nd_s [LAT+1];
	logic signed [WORD_BITS-1:0] qlo [3];
	logic signed [WORD_BITS-1:0] qhi [3];
	logic acc;
	logic [2*WORD_BITS+1:0] res;

	// The pipeline advances as one and freezes while a finished result waits.
	assign en = !v_s[LAT] || out_ready;
	assign job_ready = en;
	assign acc = job_valid && job_ready;
	assign v_s[0] = acc;
	assign act_s[0] = job.active;
	assign ins_s[0] = job.in_slab;
	assign nd_s[0] = job.no_dir;

	for (genvar a = 0; a < 3; a++) begin : g_ax
		rbsi_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lo (
			.clk(clk), .en(en), .num(job.num_lo[a][WORD_BITS:0]),
			.den(job.dir[a][WORD_BITS-1:0]), .quo(qlo[a]));
		rbsi_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_hi (
			.clk(clk), .en(en), .num(job.num_hi[a][WORD_BITS:0]),
			.den(job.dir[a][WORD_BITS-1:0]), .quo(qhi[a]));
	end

	for (genvar i = 0; i < LAT; i++) begin : g_sb
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (en) v_s[i+1] <= v_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				act_s[i+1] <= act_s[i];
				ins_s[i+1] <= ins_s[i];
				nd_s[i+1] <= nd_s[i];
			end
		end
	end

	always_comb begin
		logic signed [WORD_BITS-1:0] tl, th, mn, mx;
		logic have, hit;
		tl = '0; th = '0; have = 1'b0;
		for (int a = 0; a < 3; a++) begin
			mn = (qlo[a] < qhi[a]) ? qlo[a] : qhi[a];
			mx = (qlo[a] < qhi[a]) ? qhi[a] : qlo[a];
			if (act_s[LAT][a]) begin
				if (!have) begin
					tl = mn; th = mx; have = 1'b1;
				end else begin
					if (mn > tl) tl = mn;
					if (mx < th) th = mx;
				end
			end
		end
		hit = !nd_s[LAT] && ins_s[LAT] && (tl <= th);
		if (!hit) begin
			tl = '0; th = '0;
		end
		res = {nd_s[LAT], hit, th, tl};
	end

	assign out_valid = v_s[LAT];
	assign out_data = res;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("waiting result changed");
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res[2*WORD_BITS+1] |-> !res[2*WORD_BITS]) else $error("hit with no direction");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !res[2*WORD_BITS] |-> res[2*WORD_BITS-1:0] == '0)
		else $error("miss with nonzero interval");
endmodule

>>> hdl/ray_box_slab_interval_top.sv
// Top level of the ray/box slab interval block.
// Depends on rbsi_pkg, rbsi_if, rbsi_front, rbsi_back, rbsi_div.
`timescale 1ns / 1ps
// Usage: the in channel carries one request per item: origin, direction and
// box bounds, twelve signed fixed point words packed origin_x first at the
// low end. The out channel carries t_low (low word), t_high, hit and
// no_direction (top bit). A request is taken when valid and ready are high.
// While in ready is high, one request enters per cycle. The front part
// classifies axes and forms slab numerators into a two entry queue; the
// back part runs six restoring dividers pipelined one quotient bit per
// stage. A result is offered once its request has passed the front queue
// and then every divider stage. With the receiver ready, one result
// leaves per cycle.
// When a result waits on a stalled receiver the whole back pipeline freezes;
// the front queue then takes up to two more requests and in ready drops.
// Intake resumes as soon as the receiver takes the waiting result.
// Reset clears all valid state; nothing else needs clearing.
module ray_box_slab_interval_top #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	rbsi_if.sink in_ch,
	rbsi_if.source out_ch
);
	// The word width is fixed by the package so the job type matches it.
	localparam int WORD_BITS = rbsi_pkg::WBITS;

	logic job_valid, job_ready;
	rbsi_pkg::rbsi_job_t job;

	rbsi_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_data(in_ch.data[12*WORD_BITS-1:0]), .job_valid(job_valid),
		.job_ready(job_ready), .job(job));

	rbsi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_ready(job_ready),
		.job(job), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_data(out_ch.data[2*WORD_BITS+1:0]));
endmodule

>>> test/tb.sv
// Self-checking testbench for ray_box_slab_interval_top: random and directed requests,
// slab-interval prediction in the testbench and field-by-field result checks.
// Depends on rbsi_pkg, rbsi_if and the ray_box_slab_interval_top RTL.
`timescale 1ns / 1ps
module tb;
	localparam int WBITS = rbsi_pkg::WBITS;
	localparam int AXES = rbsi_pkg::AXES;
	localparam int FRAC = 16;
	localparam int NFIELDS = 12;
	localparam int IN_W = NFIELDS * WBITS;
	localparam int OUT_W = 2 * WBITS + 2;
	localparam int RANDOM_ITEMS = 1200;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam logic signed [WBITS-1:0] T_MAX = {1'b0, {(WBITS-1){1'b1}}};
	localparam logic signed [WBITS-1:0] T_MIN = {1'b1, {(WBITS-1){1'b0}}};
	localparam logic [WBITS-1:0] ONE = 32'h0001_0000;

	// Field order matches the packing on the in channel, origin_x at the low end.
	typedef enum int {
		ORG_X, ORG_Y, ORG_Z, DIR_X, DIR_Y, DIR_Z,
		BOX_X_LO, BOX_X_HI, BOX_Y_LO, BOX_Y_HI, BOX_Z_LO, BOX_Z_HI
	} field_e;

	typedef struct packed {
		logic no_direction;
		logic hit;
		logic signed [WBITS-1:0] t_high;
		logic signed [WBITS-1:0] t_low;
	} interval_t;

	logic clk;
	logic arst_n;
	rbsi_if #(.W(IN_W)) ray_ch ();
	rbsi_if #(.W(OUT_W)) span_ch ();

	ray_box_slab_interval_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(ray_ch.sink),
		.out_ch(span_ch.source)
	);

	logic [IN_W-1:0] ray_queue[$];
	interval_t span_queue[$];
	int accepted;
	int cycles;
	bit failed;
	bit hold_armed;
	int hold_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Slab parameter (bound - org) * 2^FRAC / d, truncated toward zero and saturated.
	function automatic logic signed [WBITS-1:0] slab_param(longint bound, longint org,
			longint d);
		longint n;
		longint dm;
		longint q;
		bit neg;
		neg = bound < org;
		n = neg ? org - bound : bound - org;
		if (d < 0) begin
			dm = -d;
			neg = !neg;
		end else begin
			dm = d;
		end
		q = (n <<< FRAC) / dm;
		if (q >= (longint'(1) <<< (WBITS - 1)))
			return neg ? T_MIN : T_MAX;
		return neg ? WBITS'(-q) : WBITS'(q);
	endfunction

	function automatic interval_t predict_interval(logic [IN_W-1:0] ray);
		longint org, d, lo, hi;
		logic signed [WBITS-1:0] p, q, mn, mx, tl, th;
		bit have, in_slab;
		interval_t r;
		have = 0;
		in_slab = 1;
		tl = '0;
		th = '0;
		r.no_direction = 1'b1;
		for (int a = 0; a < AXES; a++) begin
			org = $signed(ray[(ORG_X + a) * WBITS +: WBITS]);
			d = $signed(ray[(DIR_X + a) * WBITS +: WBITS]);
			lo = $signed(ray[(BOX_X_LO + 2 * a) * WBITS +: WBITS]);
			hi = $signed(ray[(BOX_X_HI + 2 * a) * WBITS +: WBITS]);
			if (d != 0) begin
				r.no_direction = 1'b0;
				p = slab_param(lo, org, d);
				q = slab_param(hi, org, d);
				mn = (p < q) ? p : q;
				mx = (p < q) ? q : p;
				if (!have) begin
					tl = mn;
					th = mx;
					have = 1;
				end else begin
					if (mn > tl) tl = mn;
					if (mx < th) th = mx;
				end
			end else if (org < lo || org > hi) begin
				in_slab = 0;
			end
		end
		r.hit = !r.no_direction && in_slab && (tl <= th);
		r.t_low = r.hit ? tl : '0;
		r.t_high = r.hit ? th : '0;
		return r;
	endfunction

	function automatic logic [WBITS-1:0] any_word();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return '0;
			2: begin
				case ($urandom_range(0, 3))
					0: return T_MAX;
					1: return T_MIN;
					2: return '1;
					default: return 32'd1;
				endcase
			end
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	// A line near a box of moderate size: most of these hit or just miss.
	function automatic logic [IN_W-1:0] well_formed_ray();
		logic [IN_W-1:0] ray;
		logic [WBITS-1:0] c, h;
		for (int a = 0; a < AXES; a++) begin
			c = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			h = $urandom_range(0, 32'h0040_0000);
			ray[(BOX_X_LO + 2 * a) * WBITS +: WBITS] = c - h;
			ray[(BOX_X_HI + 2 * a) * WBITS +: WBITS] = c + h;
			ray[(ORG_X + a) * WBITS +: WBITS] = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
			case ($urandom_range(0, 9))
				0: ray[(DIR_X + a) * WBITS +: WBITS] = '0;
				1: ray[(DIR_X + a) * WBITS +: WBITS] = $urandom;
				default: ray[(DIR_X + a) * WBITS +: WBITS] =
					$urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			endcase
			if ($urandom_range(0, 19) == 0) begin
				ray[(BOX_X_LO + 2 * a) * WBITS +: WBITS] = c + h;
				ray[(BOX_X_HI + 2 * a) * WBITS +: WBITS] = c - h;
			end
		end
		return ray;
	endfunction

	function automatic logic [IN_W-1:0] make_ray(logic [WBITS-1:0] ox, oy, oz,
			logic [WBITS-1:0] dx, dy, dz, logic [WBITS-1:0] xl, xh, yl, yh, zl, zh);
		return {zh, zl, yh, yl, xh, xl, dz, dy, dx, oz, oy, ox};
	endfunction

	// Request driver: idles with a chance of about 38 in a hundred, except for a
	// stretch of requests in the middle of the random part where it never idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_ch.valid <= 1'b0;
			ray_ch.data <= '0;
		end else begin
			if (ray_ch.valid && ray_ch.ready) begin
				span_queue.push_back(predict_interval(ray_ch.data));
				accepted++;
			end
			if (!ray_ch.valid || ray_ch.ready) begin
				if (ray_queue.size() > 0 &&
						((accepted >= 500 && accepted < 700) || $urandom_range(0, 99) >= 38)) begin
					ray_ch.valid <= 1'b1;
					ray_ch.data <= ray_queue.pop_front();
				end else begin
					ray_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and ready generator. Once, while requests keep coming,
	// ready is held low for a long stretch so the block fills and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_ch.ready <= 1'b0;
			hold_armed <= 1'b1;
			hold_left <= 0;
		end else begin
			if (span_ch.valid && span_ch.ready) begin
				if (span_queue.size() == 0) begin
					$error("result with no request pending: %h", span_ch.data);
					failed = 1;
				end else begin
					interval_t want, got;
					want = span_queue.pop_front();
					got = span_ch.data;
					if (got.t_low !== want.t_low) begin
						$error("t_low expected %0d actual %0d", want.t_low, got.t_low);
						failed = 1;
					end
					if (got.t_high !== want.t_high) begin
						$error("t_high expected %0d actual %0d", want.t_high, got.t_high);
						failed = 1;
					end
					if (got.hit !== want.hit) begin
						$error("hit expected %0b actual %0b", want.hit, got.hit);
						failed = 1;
					end
					if (got.no_direction !== want.no_direction) begin
						$error("no_direction expected %0b actual %0b",
							want.no_direction, got.no_direction);
						failed = 1;
					end
				end
			end
			if (hold_armed && accepted >= 300) begin
				hold_armed <= 1'b0;
				hold_left <= HOLD_CYCLES;
				span_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				span_ch.ready <= 1'b0;
			end else begin
				span_ch.ready <= (accepted >= 500 && accepted < 700) ||
					($urandom_range(0, 99) >= 38);
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [IN_W-1:0] ray;
		arst_n = 1'b0;
		ray_ch.valid = 1'b0;
		ray_ch.data = '0;
		span_ch.ready = 1'b0;
		accepted = 0;
		cycles = 0;
		failed = 0;

		// Directed cases. All directions zero: empty and flagged.
		ray_queue.push_back(make_ray('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
		// Extreme words everywhere.
		ray_queue.push_back(make_ray(T_MIN, T_MIN, T_MIN, 32'd1, 32'd1, 32'd1,
			T_MIN, T_MAX, T_MIN, T_MAX, T_MIN, T_MAX));
		ray_queue.push_back(make_ray(T_MAX, T_MIN, T_MAX, T_MIN, T_MAX, '1,
			T_MIN, T_MAX, T_MAX, T_MIN, '0, T_MAX));
		ray_queue.push_back(make_ray(T_MAX, T_MAX, T_MAX, T_MIN, T_MIN, T_MIN,
			T_MIN, T_MIN, T_MIN, T_MIN, T_MIN, T_MIN));
		// Unit ray along x from the origin through a unit box.
		ray_queue.push_back(make_ray('0, '0, '0, ONE, '0, '0, ONE, 2 * ONE, -ONE, ONE, -ONE, ONE));
		// Zero direction on y with the origin exactly on each boundary.
		ray_queue.push_back(make_ray('0, ONE, '0, ONE, '0, '0, -ONE, ONE, ONE, 2 * ONE, -ONE, ONE));
		ray_queue.push_back(make_ray('0, ONE, '0, ONE, '0, '0, -ONE, ONE, '0, ONE, -ONE, ONE));
		// Zero direction on z with the origin just outside the slab.
		ray_queue.push_back(make_ray('0, '0, ONE + 1, ONE, ONE, '0, -ONE, ONE, -ONE, ONE, -ONE, ONE));
		// Touching intervals: x gives [0,1], y gives [1,2].
		ray_queue.push_back(make_ray('0, '0, '0, ONE, ONE, '0, '0, ONE, ONE, 2 * ONE, -ONE, ONE));
		// Disjoint intervals: miss.
		ray_queue.push_back(make_ray('0, '0, '0, ONE, ONE, '0, '0, ONE, 2 * ONE, 3 * ONE, -ONE, ONE));
		// Reversed bounds on a moving axis and on a still axis.
		ray_queue.push_back(make_ray('0, '0, '0, -ONE, '0, '0, 3 * ONE, ONE, -ONE, ONE, -ONE, ONE));
		ray_queue.push_back(make_ray('0, '0, '0, ONE, '0, '0, ONE, 3 * ONE, ONE, -ONE, -ONE, ONE));
		// Tiny direction: parameters saturate both ways.
		ray_queue.push_back(make_ray('0, '0, '0, 32'd1, '0, '0, -ONE, ONE, -ONE, ONE, -ONE, ONE));
		ray_queue.push_back(make_ray('0, '0, '0, '1, '1, '1, -ONE, ONE, -ONE, ONE, -ONE, ONE));
		// Truncation toward zero with negative and odd quotients.
		ray_queue.push_back(make_ray(32'd5, 32'd7, '0, 3 * ONE, -7 * ONE, 32'd3,
			-ONE, 32'd1, -32'd1, ONE, -32'd7, 32'd11));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 75) begin
				ray = well_formed_ray();
			end else begin
				for (int f = 0; f < NFIELDS; f++)
					ray[f * WBITS +: WBITS] = any_word();
			end
			ray_queue.push_back(ray);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (ray_queue.size() == 0);
		@(posedge clk);
		while (ray_ch.valid || span_queue.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (!failed) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

>>> filelist.f
hdl/rbsi_pkg.sv
hdl/rbsi_if.sv
hdl/rbsi_front.sv
hdl/rbsi_div.sv
hdl/rbsi_back.sv
hdl/ray_box_slab_interval_top.sv
test/tb.sv
